>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared constants, command codes and the map memory request type.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int CMD_W      = 3;
    localparam int BCOUNT_W   = 11;
    localparam int BSIZE_W    = 13;
    localparam int SIZE_W     = 23;
    localparam int HELD_W     = 11;
    localparam int RUN_W      = 11;
    localparam int IDX_W      = 10;
    localparam int BYTES_W    = SIZE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CMD_W-1:0] CMD_FREE       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OCCUPY     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIRST_FREE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIRST_FIT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BLK_TOTAL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

>>> rtl/bba_map_ram.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator map memory
// One occupied bit per block, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_map_ram
    import bba_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output logic     o_rdata
);

    logic r_mem [MAX_BLOCKS];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bba_seq.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator sequencer
// Walks the map one block per cycle to clear, mark, search or check runs.
// ----------------------------------------------------------------------------
module bba_seq
    import bba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [ADDR_W-1:0]   i_first_block,
    input  logic [ADDR_W-1:0]   i_last_block,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [HELD_W-1:0]   i_blocks_held,
    input  logic [RUN_W-1:0]    i_run_length,
    input  logic [BCOUNT_W-1:0] i_blk_total,
    input  logic [BSIZE_W-1:0]  i_block_size,
    input  logic                i_rdata,
    output t_ram_req            o_req,
    output logic                o_busy,
    output logic                o_done,
    output logic                o_found,
    output logic [IDX_W-1:0]    o_block_index
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_end;
    logic                r_wbit;
    logic [CMD_W-1:0]    r_op;
    logic                r_pend;
    logic [ADDR_W-1:0]   r_pidx;
    logic [SIZE_W-1:0]   r_size;
    logic [BSIZE_W-1:0]  r_bs;
    logic [BYTES_W-1:0]  r_run_bytes;
    logic [ADDR_W-1:0]   r_run_start;
    logic                r_done;
    logic                r_found;
    logic [IDX_W-1:0]    r_index;

    logic [CNT_W-1:0]    n_live;
    logic [CNT_W-1:0]    n_range_end;
    logic [CNT_W:0]      n_chk_start;
    logic [CNT_W+1:0]    n_chk_end;
    logic [BYTES_W-1:0]  n_run_bytes;
    logic                n_fit_hit;
    logic                n_more;

    always_comb begin
        if (i_blk_total > BCOUNT_W'(MAX_BLOCKS)) begin
            n_live = CNT_W'(MAX_BLOCKS);
        end else begin
            n_live = CNT_W'(i_blk_total);
        end
        if ({1'b0, i_last_block} + 1'b1 < n_live) begin
            n_range_end = {1'b0, i_last_block} + 1'b1;
        end else begin
            n_range_end = n_live;
        end
        n_chk_start = (CNT_W+1)'(i_first_block) + (CNT_W+1)'(i_blocks_held);
        n_chk_end   = (CNT_W+2)'(n_chk_start) + (CNT_W+2)'(i_run_length);
        n_run_bytes = r_run_bytes + BYTES_W'(r_bs);
        n_fit_hit   = (n_run_bytes >= BYTES_W'(r_size));
        n_more      = (r_addr < r_end);
    end

    always_comb begin
        o_req.we    = 1'b0;
        o_req.waddr = r_addr[ADDR_W-1:0];
        o_req.wdata = r_wbit;
        o_req.raddr = r_addr[ADDR_W-1:0];
        unique case (r_state)
            S_CLEAR: o_req.we = 1'b1;
            S_MARK:  o_req.we = n_more;
            default: o_req.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_wbit  <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_index <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == CNT_W'(MAX_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op        <= i_cmd;
                        r_size      <= i_size_bytes;
                        r_bs        <= (i_block_size == '0) ? BSIZE_W'(1) : i_block_size;
                        r_run_bytes <= '0;
                        r_run_start <= '0;
                        r_pend      <= 1'b0;
                        r_index     <= '0;
                        unique case (i_cmd)
                            CMD_FREE, CMD_OCCUPY: begin
                                r_addr  <= CNT_W'(i_first_block);
                                r_end   <= n_range_end;
                                r_wbit  <= (i_cmd == CMD_OCCUPY);
                                r_state <= S_MARK;
                            end
                            CMD_FIRST_FREE, CMD_FIRST_FIT: begin
                                r_addr  <= '0;
                                r_end   <= n_live;
                                r_state <= S_SCAN;
                            end
                            CMD_CHECK: begin
                                if (i_run_length == '0) begin
                                    r_found <= 1'b1;
                                    r_done  <= 1'b1;
                                end else if (n_chk_end > (CNT_W+2)'(n_live)) begin
                                    r_found <= 1'b0;
                                    r_done  <= 1'b1;
                                end else begin
                                    r_addr  <= n_chk_start[CNT_W-1:0];
                                    r_end   <= n_chk_end[CNT_W-1:0];
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_found <= 1'b0;
                                r_done  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MARK: begin
                    if (n_more) begin
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_found <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (n_more) begin
                        r_addr <= r_addr + 1'b1;
                        r_pidx <= r_addr[ADDR_W-1:0];
                    end
                    r_pend <= n_more;
                    if (r_pend && r_op == CMD_FIRST_FREE && !i_rdata) begin
                        r_found <= 1'b1;
                        r_index <= IDX_W'(r_pidx);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_pend && r_op == CMD_FIRST_FIT && !i_rdata && n_fit_hit) begin
                        r_found <= 1'b1;
                        r_index <= IDX_W'(r_run_start);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_pend && r_op == CMD_CHECK && i_rdata) begin
                        r_found <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!r_pend && !n_more) begin
                        r_found <= (r_op == CMD_CHECK);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    if (r_pend) begin
                        if (i_rdata) begin
                            r_run_bytes <= '0;
                            r_run_start <= r_pidx + 1'b1;
                        end else begin
                            r_run_bytes <= n_run_bytes;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_block_index = r_index;

endmodule

>>> rtl/block_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// A range command walks its blocks up to the live block count; a search or run
// check walks at most the live block count, one map block per cycle.
// Immediate answers (zero-length or out-of-range checks, unknown codes) come
// straight from the idle state without reading the map.
// One command at a time; the result strobe lasts one cycle and cannot stall.
// After reset all 1024 map bits are cleared while busy is high.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_top
    import bba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ADDR_W-1:0]     i_first_block,
    input  logic [ADDR_W-1:0]     i_last_block,
    input  logic [SIZE_W-1:0]     i_size_bytes,
    input  logic [HELD_W-1:0]     i_blocks_held,
    input  logic [RUN_W-1:0]      i_run_length,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_block_index
);

    logic [BCOUNT_W-1:0] r_blk_total;
    logic [BSIZE_W-1:0]  r_block_size;
    t_ram_req            ram_req;
    logic                ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_total  <= BCOUNT_W'(1024);
            r_block_size <= BSIZE_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BLK_TOTAL:  r_blk_total  <= i_cfg_data[BCOUNT_W-1:0];
                REG_BLOCK_SIZE: r_block_size <= i_cfg_data[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    bba_map_ram u_map (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    bba_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_first_block (i_first_block),
        .i_last_block  (i_last_block),
        .i_size_bytes  (i_size_bytes),
        .i_blocks_held (i_blocks_held),
        .i_run_length  (i_run_length),
        .i_blk_total   (r_blk_total),
        .i_block_size  (r_block_size),
        .i_rdata       (ram_rdata),
        .o_req         (ram_req),
        .o_busy        (busy),
        .o_done        (o_valid),
        .o_found       (o_found),
        .o_block_index (o_block_index)
    );

endmodule
